// ===== rtl/mccp_pkg.sv =====
// Shared constants and request types for the Monte Carlo call option pricer.
`default_nettype none

package mccp_pkg;

    localparam int PATH_COUNT_WIDTH = 24;

    localparam logic [31:0] LN2_Q32   = 32'd2977044472;
    localparam logic [31:0] LOG2E_Q30 = 32'd1549082005;
    localparam logic [31:0] ONE_Q24   = 32'd16777216;
    localparam logic [31:0] SIG_MAX   = 32'h8000_0000;
    localparam logic [31:0] SAT32     = 32'hFFFF_FFFF;
    localparam logic signed [39:0] EXP_LIM = 40'sd385875968;
    localparam logic [3:0]  LAST_TERM = 4'd12;

    typedef enum logic [2:0] {
        CFG_SPOT   = 3'd0,
        CFG_STRIKE = 3'd1,
        CFG_MAT    = 3'd2,
        CFG_RATE   = 3'd3,
        CFG_VOL    = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic        start;
        logic [63:0] dividend;
        logic [31:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic        start;
        logic [63:0] value;
    } t_sqrt_req;

endpackage

`default_nettype wire

// ===== rtl/mccp_mul.sv =====
// Shared 33 x 33 signed multiplier with registered product.
`default_nettype none

module mccp_mul (
    input  wire logic               i_clk,
    input  wire logic signed [32:0] i_a,
    input  wire logic signed [32:0] i_b,
    output logic signed [65:0]      o_p
);

    logic signed [65:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule

`default_nettype wire

// ===== rtl/mccp_div.sv =====
// Shared restoring divider, 64-bit dividend by 32-bit divisor, one bit a cycle.
`default_nettype none

module mccp_div (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire mccp_pkg::t_div_req i_req,
    output logic                   o_busy,
    output logic [63:0]            o_quot
);
    import mccp_pkg::*;

    logic        r_busy;
    logic [6:0]  r_cnt;
    logic [63:0] r_q;
    logic [31:0] r_rem;
    logic [31:0] r_div;

    logic [32:0] w_t;
    logic        w_ge;
    logic [32:0] w_sub;

    always_comb begin
        w_t   = {r_rem, r_q[63]};
        w_ge  = w_t >= {1'b0, r_div};
        w_sub = w_t - {1'b0, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            // short dividends need only the low half of the steps
            r_cnt  <= (i_req.dividend[63:32] == 32'd0) ? 7'd32 : 7'd64;
        end else if (r_busy) begin
            r_cnt <= r_cnt - 7'd1;
            if (r_cnt == 7'd1) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_q   <= (i_req.dividend[63:32] == 32'd0) ? {i_req.dividend[31:0], 32'd0}
                                                      : i_req.dividend;
            r_rem <= '0;
            r_div <= i_req.divisor;
        end else if (r_busy) begin
            r_q   <= {r_q[62:0], w_ge};
            r_rem <= w_ge ? w_sub[31:0] : w_t[31:0];
        end
    end

    assign o_busy = r_busy;
    assign o_quot = r_q;

endmodule

`default_nettype wire

// ===== rtl/mccp_sqrt.sv =====
// Digit-by-digit integer square root of a 64-bit value, one result bit a cycle.
`default_nettype none

module mccp_sqrt (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire mccp_pkg::t_sqrt_req i_req,
    output logic                    o_busy,
    output logic [31:0]             o_root
);
    import mccp_pkg::*;

    logic        r_busy;
    logic [63:0] r_v;
    logic [63:0] r_res;
    logic [63:0] r_bit;

    logic [63:0] w_rb;
    logic        w_ge;

    always_comb begin
        w_rb = r_res + r_bit;
        w_ge = r_v >= w_rb;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
        end else if (r_busy && r_bit[0]) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_v   <= i_req.value;
            r_res <= '0;
            r_bit <= 64'h4000_0000_0000_0000;
        end else if (r_busy) begin
            if (w_ge) begin
                r_v   <= r_v - w_rb;
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign o_busy = r_busy;
    assign o_root = r_res[31:0];

endmodule

`default_nettype wire

// ===== rtl/monte_carlo_call_option_pricer.sv =====
// Monte Carlo European call pricer: sequencer around shared multiply, divide, root units.
//
// Usage: write spot, strike, maturity, rate and volatility on the cfg channel
// (always ready, index 0..4, others ignored) while no run is in progress.
// Send one standard-normal draw per path on s_axis (tdata = Q4.28 sample,
// tlast marks the final path). s_axis_tready is high only while the sequencer
// is idle. A path's time is set mainly by the eleven series-term divisions
// of the exponential in the shared divider. The first path of a run adds
// the setup states plus one more exponential for the discount factor. The
// final path adds three 64-bit divisions (only one below two paths) and a
// 32-step square root. The result (mean and standard error, too-few-paths
// flag in tuser) then sits in the output register until taken; if the
// receiver stalls, the next run's final path waits for it to drain.
// Reset (synchronous, active low) restores the configuration defaults and
// clears the accumulators and path count.
`default_nettype none

module monte_carlo_call_option_pricer (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,  // [31:0] normal_sample
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [63:0]      m_axis_tdata,  // [31:0] price_estimate, [63:32] standard_error
    output logic             m_axis_tuser   // [0] too_few_paths
);
    import mccp_pkg::*;

    localparam logic [PATH_COUNT_WIDTH-1:0] CNT_MAX = {PATH_COUNT_WIDTH{1'b1}};

    typedef enum logic [33:0] {
        ST_IDLE  = 34'd1 << 0,
        ST_SIG   = 34'd1 << 1,
        ST_D     = 34'd1 << 2,
        ST_DISCX = 34'd1 << 3,
        ST_DRIFT = 34'd1 << 4,
        ST_ROOT  = 34'd1 << 5,
        ST_DIFF  = 34'd1 << 6,
        ST_PX    = 34'd1 << 7,
        ST_PX2   = 34'd1 << 8,
        ST_PAY   = 34'd1 << 9,
        ST_DP    = 34'd1 << 10,
        ST_ACC   = 34'd1 << 11,
        ST_END   = 34'd1 << 12,
        ST_ECHK  = 34'd1 << 13,
        ST_EK    = 34'd1 << 14,
        ST_ER    = 34'd1 << 15,
        ST_EADJ  = 34'd1 << 16,
        ST_ET1   = 34'd1 << 17,
        ST_ETI   = 34'd1 << 18,
        ST_ETP   = 34'd1 << 19,
        ST_ETD   = 34'd1 << 20,
        ST_EPROD = 34'd1 << 21,
        ST_ESH   = 34'd1 << 22,
        ST_FDIV  = 34'd1 << 23,
        ST_FDIVW = 34'd1 << 24,
        ST_FM2   = 34'd1 << 25,
        ST_FM2R  = 34'd1 << 26,
        ST_FNLO  = 34'd1 << 27,
        ST_FNHI  = 34'd1 << 28,
        ST_FDIFF = 34'd1 << 29,
        ST_FDV1  = 34'd1 << 30,
        ST_FDV2  = 34'd1 << 31,
        ST_FSQ   = 34'd1 << 32,
        ST_FOUT  = 34'd1 << 33
    } t_state;

    t_state r_state, n_state;

    // configuration
    logic [31:0] r_spot, r_strike, r_mat, r_rate, r_vol;

    // run state
    logic [63:0]                 r_psum, r_qsum;
    logic [PATH_COUNT_WIDTH-1:0] r_cnt;
    logic signed [31:0]          r_drift;
    logic [31:0]                 r_diffu, r_disc;
    logic                        r_first;

    // working registers
    logic [31:0]        r_z;
    logic               r_last;
    logic signed [32:0] r_d28;
    logic signed [39:0] r_x;
    logic signed [7:0]  r_k;
    logic signed [47:0] r_r;
    logic [31:0]        r_term;
    logic [33:0]        r_sum;
    logic [3:0]         r_i;
    logic [31:0]        r_e;
    logic [31:0]        r_dp;
    logic [31:0]        r_mean;
    logic               r_few;
    logic [31:0]        r_err;
    logic [63:0]        r_m2, r_lo, r_nm2;

    // output register
    logic        r_ovalid;
    logic [63:0] r_odata;
    logic        r_ouser;

    // shared units
    logic signed [32:0] w_ma, w_mb;
    logic signed [65:0] w_p;
    t_div_req           w_dreq;
    t_sqrt_req          w_sreq;
    logic               w_dbusy, w_sbusy;
    logic [63:0]        w_quot;
    logic [31:0]        w_root;

    mccp_mul u_mul (
        .i_clk (i_clk),
        .i_a   (w_ma),
        .i_b   (w_mb),
        .o_p   (w_p)
    );

    mccp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_dreq),
        .o_busy  (w_dbusy),
        .o_quot  (w_quot)
    );

    mccp_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_sreq),
        .o_busy  (w_sbusy),
        .o_root  (w_root)
    );

    // derived values
    logic [31:0]        w_sig, w_a_exp, w_payoff, w_dp, w_nx_dummy;
    logic [31:0]        w_n;
    logic signed [65:0] w_d, w_nx, w_r66;
    logic [39:0]        w_xpath;
    logic [64:0]        w_ptot, w_qtot, w_ntot;
    logic [63:0]        w_diffv;
    logic signed [8:0]  w_s;
    logic [8:0]         w_ns;
    logic [63:0]        w_lim, w_shr, w_prod;
    logic [31:0]        w_exp_out;
    logic               w_out_free;

    always_comb begin
        w_sig      = (r_vol > SIG_MAX) ? SIG_MAX : r_vol;
        w_a_exp    = r_first ? ONE_Q24 : r_spot;
        w_payoff   = (r_e > r_strike) ? (r_e - r_strike) : 32'd0;
        w_dp       = (|w_p[63:56]) ? SAT32 : w_p[55:24];
        w_nx_dummy = '0;
        w_n        = 32'(r_cnt);
        w_d        = $signed({{4{r_rate[31]}}, r_rate, 30'd0}) - (w_p >>> 1);
        w_nx       = -w_p;
        w_r66      = $signed({{18{r_x[39]}}, r_x, 8'd0}) - w_p;
        w_xpath    = {{4{r_drift[31]}}, r_drift, 4'd0} + {{2{w_p[65]}}, w_p[65:28]};
        w_ptot     = {1'b0, r_psum} + {33'd0, r_dp};
        w_qtot     = {1'b0, r_qsum} + {1'b0, w_p[63:0]};
        w_ntot     = {1'b0, w_p[31:0], 32'd0} + {1'b0, r_lo};
        w_diffv    = (r_qsum > r_nm2) ? (r_qsum - r_nm2) : 64'd0;
        w_out_free = !r_ovalid || m_axis_tready;
    end

    // final scaling of a * e^f by 2^k
    always_comb begin
        w_prod = w_p[63:0];
        w_s    = 9'sd30 - $signed({r_k[7], r_k});
        w_ns   = -w_s;
        w_lim  = {32'd0, SAT32} >> w_ns[5:0];
        w_shr  = w_prod >> w_s[5:0];
        if (w_s > 9'sd63) begin
            w_exp_out = 32'd0;
        end else if (w_s <= 9'sd0) begin
            w_exp_out = (w_prod > w_lim) ? SAT32 : 32'(w_prod << w_ns[5:0]);
        end else begin
            w_exp_out = (|w_shr[63:32]) ? SAT32 : w_shr[31:0];
        end
    end

    // multiplier operand select
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        unique case (r_state)
            ST_SIG: begin
                w_ma = $signed({1'b0, w_sig});
                w_mb = $signed({1'b0, w_sig});
            end
            ST_D: begin
                w_ma = $signed({r_rate[31], r_rate});
                w_mb = $signed({1'b0, r_mat});
            end
            ST_DISCX: begin
                w_ma = r_d28;
                w_mb = $signed({1'b0, r_mat});
            end
            ST_ROOT: begin
                w_ma = $signed({1'b0, w_sig});
                w_mb = $signed({1'b0, w_root});
            end
            ST_PX: begin
                w_ma = $signed({1'b0, r_diffu});
                w_mb = $signed({r_z[31], r_z});
            end
            ST_ECHK: begin
                w_ma = $signed(r_x[32:0]);
                w_mb = $signed({1'b0, LOG2E_Q30});
            end
            ST_EK: begin
                w_ma = $signed({{25{w_p[61]}}, w_p[61:54]});
                w_mb = $signed({1'b0, LN2_Q32});
            end
            ST_ETI: begin
                w_ma = $signed({1'b0, r_term});
                w_mb = $signed({1'b0, r_r[31:0]});
            end
            ST_EPROD: begin
                w_ma = $signed({1'b0, w_a_exp});
                w_mb = $signed({1'b0, r_sum[33:2]});
            end
            ST_PAY: begin
                w_ma = $signed({1'b0, r_disc});
                w_mb = $signed({1'b0, w_payoff});
            end
            ST_DP: begin
                w_ma = $signed({1'b0, w_dp});
                w_mb = $signed({1'b0, w_dp});
            end
            ST_FM2: begin
                w_ma = $signed({1'b0, r_mean});
                w_mb = $signed({1'b0, r_mean});
            end
            ST_FM2R: begin
                w_ma = $signed({1'b0, w_n});
                w_mb = $signed({1'b0, w_p[31:0]});
            end
            ST_FNLO: begin
                w_ma = $signed({1'b0, w_n});
                w_mb = $signed({1'b0, r_m2[63:32]});
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    // divider and root requests
    always_comb begin
        w_dreq = '0;
        w_sreq = '0;
        unique case (r_state)
            ST_SIG: begin
                w_sreq.start = 1'b1;
                w_sreq.value = {8'd0, r_mat, 24'd0};
            end
            ST_ETP: begin
                w_dreq.start    = 1'b1;
                w_dreq.dividend = {32'd0, w_p[63:32]};
                w_dreq.divisor  = {28'd0, r_i};
            end
            ST_FDIV: begin
                w_dreq.start    = 1'b1;
                w_dreq.dividend = r_psum;
                w_dreq.divisor  = w_n;
            end
            ST_FDIFF: begin
                w_dreq.start    = 1'b1;
                w_dreq.dividend = w_diffv;
                w_dreq.divisor  = w_n - 32'd1;
            end
            ST_FDV1: begin
                w_dreq.start    = !w_dbusy;
                w_dreq.dividend = w_quot;
                w_dreq.divisor  = w_n;
            end
            ST_FDV2: begin
                w_sreq.start = !w_dbusy;
                w_sreq.value = w_quot;
            end
            default: begin
                w_dreq = '0;
                w_sreq = '0;
            end
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    if (r_cnt == '0) begin
                        n_state = ST_SIG;
                    end else if (r_cnt == CNT_MAX) begin
                        n_state = ST_END;
                    end else begin
                        n_state = ST_PX;
                    end
                end
            end
            ST_SIG:   n_state = ST_D;
            ST_D:     n_state = ST_DISCX;
            ST_DISCX: n_state = ST_DRIFT;
            ST_DRIFT: n_state = ST_ROOT;
            ST_ROOT:  n_state = w_sbusy ? ST_ROOT : ST_DIFF;
            ST_DIFF:  n_state = ST_ECHK;
            ST_PX:    n_state = ST_PX2;
            ST_PX2:   n_state = ST_ECHK;
            ST_ECHK: begin
                if (w_a_exp == 32'd0 || r_x < -EXP_LIM || r_x >= EXP_LIM) begin
                    n_state = r_first ? ST_PX : ST_PAY;
                end else begin
                    n_state = ST_EK;
                end
            end
            ST_EK:    n_state = ST_ER;
            ST_ER:    n_state = ST_EADJ;
            ST_EADJ: begin
                if (!r_r[47] && r_r < $signed({16'd0, LN2_Q32})) begin
                    n_state = ST_ET1;
                end
            end
            ST_ET1:   n_state = ST_ETI;
            ST_ETI:   n_state = ST_ETP;
            ST_ETP:   n_state = ST_ETD;
            ST_ETD: begin
                if (!w_dbusy) begin
                    n_state = (r_i == LAST_TERM) ? ST_EPROD : ST_ETI;
                end
            end
            ST_EPROD: n_state = ST_ESH;
            ST_ESH:   n_state = r_first ? ST_PX : ST_PAY;
            ST_PAY:   n_state = ST_DP;
            ST_DP:    n_state = ST_ACC;
            ST_ACC:   n_state = ST_END;
            ST_END:   n_state = r_last ? ST_FDIV : ST_IDLE;
            ST_FDIV:  n_state = ST_FDIVW;
            ST_FDIVW: begin
                if (!w_dbusy) begin
                    n_state = (r_cnt < PATH_COUNT_WIDTH'(2)) ? ST_FOUT : ST_FM2;
                end
            end
            ST_FM2:   n_state = ST_FM2R;
            ST_FM2R:  n_state = ST_FNLO;
            ST_FNLO:  n_state = ST_FNHI;
            ST_FNHI:  n_state = ST_FDIFF;
            ST_FDIFF: n_state = ST_FDV1;
            ST_FDV1:  n_state = w_dbusy ? ST_FDV1 : ST_FDV2;
            ST_FDV2:  n_state = w_dbusy ? ST_FDV2 : ST_FSQ;
            ST_FSQ:   n_state = w_sbusy ? ST_FSQ : ST_FOUT;
            ST_FOUT:  n_state = w_out_free ? ST_IDLE : ST_FOUT;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spot   <= 32'd6553600;
            r_strike <= 32'd6553600;
            r_mat    <= 32'd16777216;
            r_rate   <= 32'd53687091;
            r_vol    <= 32'd214748365;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_SPOT:   r_spot   <= i_cfg_data;
                CFG_STRIKE: r_strike <= i_cfg_data;
                CFG_MAT:    r_mat    <= i_cfg_data;
                CFG_RATE:   r_rate   <= i_cfg_data;
                CFG_VOL:    r_vol    <= i_cfg_data;
                default:    ;
            endcase
        end
    end

    // run state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_psum   <= '0;
            r_qsum   <= '0;
            r_cnt    <= '0;
            r_first  <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_ovalid && m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_first <= (r_cnt == '0);
                    end
                end
                ST_PX: begin
                    r_first <= 1'b0;
                end
                ST_ACC: begin
                    r_psum <= w_ptot[64] ? {64{1'b1}} : w_ptot[63:0];
                    r_qsum <= w_qtot[64] ? {64{1'b1}} : w_qtot[63:0];
                    r_cnt  <= r_cnt + 1'b1;
                end
                ST_FOUT: begin
                    if (w_out_free) begin
                        r_ovalid <= 1'b1;
                        r_psum   <= '0;
                        r_qsum   <= '0;
                        r_cnt    <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                r_z    <= s_axis_tdata;
                r_last <= s_axis_tlast;
            end
            ST_D:     r_d28   <= w_d[64:32];
            ST_DISCX: r_x     <= {{4{w_nx[65]}}, w_nx[65:30]};
            ST_DRIFT: r_drift <= w_p[63:32];
            ST_DIFF:  r_diffu <= w_p[61:30];
            ST_PX: begin
                if (r_first) begin
                    r_disc <= r_e;
                end
            end
            ST_PX2:   r_x <= w_xpath;
            ST_ECHK: begin
                // out-of-range arguments and zero scale settle at once
                r_e <= (w_a_exp == 32'd0 || r_x < -EXP_LIM) ? 32'd0 : SAT32;
            end
            ST_EK:    r_k <= w_p[61:54];
            ST_ER:    r_r <= w_r66[47:0];
            ST_EADJ: begin
                if (r_r[47]) begin
                    r_r <= r_r + $signed({16'd0, LN2_Q32});
                    r_k <= r_k - 8'sd1;
                end else if (r_r >= $signed({16'd0, LN2_Q32})) begin
                    r_r <= r_r - $signed({16'd0, LN2_Q32});
                    r_k <= r_k + 8'sd1;
                end
            end
            ST_ET1: begin
                r_term <= r_r[31:0];
                r_sum  <= {2'b01, r_r[31:0]};
                r_i    <= 4'd2;
            end
            ST_ETD: begin
                if (!w_dbusy) begin
                    r_term <= w_quot[31:0];
                    r_sum  <= r_sum + {2'd0, w_quot[31:0]};
                    r_i    <= r_i + 4'd1;
                end
            end
            ST_ESH:   r_e  <= w_exp_out;
            ST_DP:    r_dp <= w_dp;
            ST_FDIVW: begin
                r_mean <= (|w_quot[63:32]) ? SAT32 : w_quot[31:0];
                r_few  <= r_cnt < PATH_COUNT_WIDTH'(2);
                r_err  <= '0;
            end
            ST_FM2R:  r_m2 <= w_p[63:0];
            ST_FNLO:  r_lo <= w_p[63:0];
            ST_FNHI:  r_nm2 <= ((|w_p[63:32]) || w_ntot[64]) ? {64{1'b1}} : w_ntot[63:0];
            ST_FSQ:   r_err <= w_root;
            ST_FOUT: begin
                if (w_out_free) begin
                    r_odata <= {r_err, r_mean};
                    r_ouser <= r_few;
                end
            end
            default: ;
        endcase
    end

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_ouser;

`ifndef SYNTHESIS
    a_cnt_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ACC) |=> (r_cnt == $past(r_cnt) + 1'b1))
        else $error("path count did not advance by one on accumulation");

    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_dreq.start |-> !w_dbusy)
        else $error("divider started while busy");

    a_sqrt_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_sreq.start |-> !w_sbusy)
        else $error("root unit started while busy");

    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FOUT && w_out_free) |=> (r_ovalid && r_cnt == '0))
        else $error("result not loaded or run not cleared");
`endif

endmodule

`default_nettype wire
